### hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int FADDR_W     = 24;
   localparam int BYTES_W     = 25;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 104;

   localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_MEMORY   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_ADDRESS = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DOUBLE_FREE = 2'd3;

   // Bytes kept by the system below the map itself.
   localparam logic [FADDR_W-1:0] RESERVED_BASE      = 24'h20_0000;
   localparam logic [BYTES_W-1:0] MEMORY_BYTES_RESET = 25'h100_0000;

   // Bit offsets of the result fields inside rsp_tdata.
   localparam int OFS_PAGE_ADDR = 0;
   localparam int OFS_FREE      = 24;
   localparam int OFS_USED      = 49;
   localparam int OFS_TOTAL     = 74;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_CALC,
      ST_INIT_FILL,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_DONE
   } bpa_state_type;

   typedef struct packed {
      logic                done;
      logic [STATUS_W-1:0] status;
      logic [FADDR_W-1:0]  page_address;
   } bpa_result_type;

endpackage

### hdl/bitmap_page_allocator_unit.sv
// Top level of the first-fit bitmap page allocator.
//
// The req channel takes one word per operation: tuser carries the kind (init,
// allocate, free) and tdata the byte address of a page to free. Every word
// gives exactly one rsp word with a status, the allocated page address and the
// free, used and total byte counts after the operation.
// memory_size is written through csr_wr_en / csr_wr_data; the user must write
// it only while the block is idle, which the block itself does not enforce;
// only an init reads it. Page map words are WORD_BITS = min(64, MAX_PAGES)
// bits wide, so the map has D = MAX_PAGES / WORD_BITS words. An init writes
// each of the D map words once, an allocate reads one map word per cycle in
// the first-fit scan, and a free reads the map word of its page, then checks
// and writes it back. An allocate before init, a free out of range or an
// unused kind goes straight to the result. One operation is worked on at a
// time; the next word is taken the cycle after the result enters the output
// register, even while that result still waits.
// After reset there are no pages: allocates report out of memory until an
// init. The map holds no meaning before the first init clears it.
// A stalled rsp_tready holds the result in place and stops the sequencer in
// its final state until the output register frees.
module bitmap_page_allocator_unit import bpa_pkg::*; #(
   parameter int MAX_PAGES  = 4096,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [23:0] free_address
   input  logic [KIND_W-1:0]      req_tuser,   // [1:0] kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [23:0] page_address, [48:24] free_bytes, [73:49] used_bytes,
   // [98:74] total_bytes, [103:99] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   input  logic                   csr_wr_en,
   input  logic [BYTES_W-1:0]     csr_wr_data
);

   localparam int CNT_W     = $clog2(MAX_PAGES + 1);
   localparam int PS        = $clog2(PAGE_BYTES);
   localparam int PROD_W    = CNT_W + PS;
   localparam int WORD_BITS = (MAX_PAGES < 64) ? MAX_PAGES : 64;
   localparam int DEPTH     = MAX_PAGES / WORD_BITS;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [BYTES_W-1:0]   memory_size_ff;
   logic                 rsp_tvalid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [FADDR_W-1:0]   rsp_paddr_ff;
   logic [BYTES_W-1:0]   rsp_free_ff, rsp_used_ff, rsp_total_ff;

   bpa_result_type       result;
   logic [CNT_W-1:0]     used_count, page_total, free_pages;
   logic [PROD_W-1:0]    free_prod, used_prod, total_prod;
   logic                 req_fire, rsp_free, rsp_load;
   logic                 mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]    mem_wr_addr, mem_rd_addr;
   logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = result.done && rsp_free;

   bpa_ctrl #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES),
      .CNT_W     (CNT_W),
      .WORD_BITS (WORD_BITS),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_fire),
      .req_kind        (req_tuser),
      .req_free_address(req_tdata[FADDR_W-1:0]),
      .memory_size     (memory_size_ff),
      .rsp_free        (rsp_free),
      .req_ready       (req_tready),
      .result          (result),
      .used_count      (used_count),
      .page_total      (page_total),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   bpa_map_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_map_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // Byte counts are page counts shifted by the page size, kept to 25 bits.
   always_comb begin
      free_pages = (used_count <= page_total) ? (page_total - used_count) : '0;
      free_prod  = PROD_W'(free_pages) << PS;
      used_prod  = PROD_W'(used_count) << PS;
      total_prod = PROD_W'(page_total) << PS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         memory_size_ff <= MEMORY_BYTES_RESET;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            memory_size_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= result.status;
         rsp_paddr_ff  <= result.page_address;
         rsp_free_ff   <= BYTES_W'(free_prod);
         rsp_used_ff   <= BYTES_W'(used_prod);
         rsp_total_ff  <= BYTES_W'(total_prod);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'b0, rsp_total_ff, rsp_used_ff, rsp_free_ff, rsp_paddr_ff};

endmodule

### hdl/bpa_map_ram.sv
// Simple dual-port page map memory with a registered read port.
module bpa_map_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] map_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= map_mem[rd_addr];
      end
   end

endmodule

### hdl/bpa_ctrl.sv
// Sequencer for init, first-fit allocation and free over the page map memory.
module bpa_ctrl import bpa_pkg::*; #(
   parameter int MAX_PAGES = 4096,
   parameter int PAGE_BYTES = 4096,
   parameter int CNT_W = $clog2(MAX_PAGES + 1),
   parameter int WORD_BITS = (MAX_PAGES < 64) ? MAX_PAGES : 64,
   parameter int ADDR_W = ((MAX_PAGES / WORD_BITS) > 1) ? $clog2(MAX_PAGES / WORD_BITS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [FADDR_W-1:0]   req_free_address,
   input  logic [BYTES_W-1:0]   memory_size,
   input  logic                 rsp_free,
   output logic                 req_ready,
   output bpa_result_type       result,
   output logic [CNT_W-1:0]     used_count,
   output logic [CNT_W-1:0]     page_total,
   output logic                 mem_wr_en,
   output logic [ADDR_W-1:0]    mem_wr_addr,
   output logic [WORD_BITS-1:0] mem_wr_data,
   output logic                 mem_rd_en,
   output logic [ADDR_W-1:0]    mem_rd_addr,
   input  logic [WORD_BITS-1:0] mem_rd_data
);

   localparam int PS    = $clog2(PAGE_BYTES);
   localparam int PG_W  = $clog2(MAX_PAGES);
   localparam int WB_W  = $clog2(WORD_BITS);
   localparam int DEPTH = MAX_PAGES / WORD_BITS;
   localparam int RD_W  = $clog2(DEPTH + 1);

   bpa_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [PG_W-1:0]      page_ff, page_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic [RD_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [FADDR_W-1:0]   paddr_ff, paddr_in;

   logic [BYTES_W-1:0]   ms_pages;
   logic [CNT_W-1:0]     total_calc;
   logic [31:0]          free_page;
   logic                 free_bad;
   logic [CNT_W:0]       map_bytes;
   logic [BYTES_W-1:0]   res_raw;
   logic [CNT_W-1:0]     reserved;
   logic [CNT_W:0]       scan_words;
   logic                 issuing;
   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] onehot;
   logic [WB_W-1:0]      bit_idx;
   logic                 found;
   logic [PG_W-1:0]      page_sel;
   logic [PG_W+PS-1:0]   pa_full;
   logic                 free_bit;

   // Word of the map for pages below count: all set before the word that holds
   // the count, a partial mask in it, clear after it.
   function automatic logic [WORD_BITS-1:0] fill_mask(input logic [CNT_W-1:0] count,
                                                      input logic [ADDR_W-1:0] word);
      logic [CNT_W-1:0] cw;
      logic [WB_W-1:0]  rem;
      cw  = count >> WB_W;
      rem = count[WB_W-1:0];
      if (CNT_W'(word) < cw) begin
         fill_mask = '1;
      end else if (CNT_W'(word) == cw) begin
         fill_mask = ~({WORD_BITS{1'b1}} << rem);
      end else begin
         fill_mask = '0;
      end
   endfunction

   always_comb begin
      ms_pages   = memory_size >> PS;
      total_calc = (ms_pages > BYTES_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(ms_pages);
      free_page  = 32'(req_free_address) >> PS;
      free_bad   = free_page >= 32'(total_ff);
      map_bytes  = ((CNT_W+1)'(total_ff) + (CNT_W+1)'(7)) >> 3;
      res_raw    = ((BYTES_W'(RESERVED_BASE) + BYTES_W'(map_bytes)) >> PS) + BYTES_W'(1);
      reserved   = (res_raw > BYTES_W'(total_ff)) ? total_ff : CNT_W'(res_raw);
      scan_words = ((CNT_W+1)'(total_ff) + (CNT_W+1)'(WORD_BITS - 1)) >> WB_W;
      issuing    = (CNT_W+1)'(rd_idx_ff) < scan_words;
   end

   // Lowest free page among the valid pages of the word now at the read port.
   always_comb begin
      cand    = ~mem_rd_data & fill_mask(total_ff, chk_idx_ff);
      onehot  = cand & (~cand + WORD_BITS'(1));
      bit_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (onehot[b]) begin
            bit_idx = bit_idx | WB_W'(b);
         end
      end
      found    = chk_valid_ff && (cand != '0);
      page_sel = (PG_W'(chk_idx_ff) << WB_W) | PG_W'(bit_idx);
      pa_full  = (PG_W+PS)'(page_sel) << PS;
      free_bit = mem_rd_data[page_ff[WB_W-1:0]];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_INIT:  state_in = ST_INIT_CALC;
                  KIND_ALLOC: state_in = (total_ff == '0) ? ST_DONE : ST_SCAN;
                  KIND_FREE:  state_in = free_bad ? ST_DONE : ST_FREE_RD;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_INIT_CALC: state_in = ST_INIT_FILL;
         ST_INIT_FILL: begin
            if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (found || !issuing) begin
               state_in = ST_DONE;
            end
         end
         ST_FREE_RD:  state_in = ST_FREE_CHK;
         ST_FREE_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Only one item is in flight and every write lands ahead of the next read
   // of its word, so the memory needs no forwarding.
   always_comb begin
      total_in     = total_ff;
      used_in      = used_ff;
      page_in      = page_ff;
      sweep_in     = sweep_ff;
      rd_idx_in    = rd_idx_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      status_in    = status_ff;
      paddr_in     = paddr_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               status_in    = STAT_OK;
               paddr_in     = '0;
               rd_idx_in    = '0;
               chk_valid_in = 1'b0;
               case (req_kind)
                  KIND_INIT: total_in = total_calc;
                  KIND_ALLOC: begin
                     if (total_ff == '0) begin
                        status_in = STAT_NO_MEMORY;
                     end
                  end
                  KIND_FREE: begin
                     page_in = PG_W'(free_page);
                     if (free_bad) begin
                        status_in = STAT_BAD_ADDRESS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT_CALC: begin
            used_in  = reserved;
            sweep_in = '0;
         end
         ST_INIT_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = fill_mask(used_ff, sweep_ff);
            sweep_in    = sweep_ff + ADDR_W'(1);
         end
         ST_SCAN: begin
            mem_rd_en    = issuing;
            mem_rd_addr  = ADDR_W'(rd_idx_ff);
            chk_valid_in = issuing;
            chk_idx_in   = ADDR_W'(rd_idx_ff);
            if (issuing) begin
               rd_idx_in = rd_idx_ff + RD_W'(1);
            end
            if (found) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_idx_ff;
               mem_wr_data = mem_rd_data | onehot;
               used_in     = used_ff + CNT_W'(1);
               paddr_in    = FADDR_W'(pa_full);
            end else if (!issuing) begin
               status_in = STAT_NO_MEMORY;
            end
         end
         ST_FREE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(page_ff >> WB_W);
         end
         ST_FREE_CHK: begin
            if (!free_bit) begin
               status_in = STAT_DOUBLE_FREE;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ADDR_W'(page_ff >> WB_W);
               mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << page_ff[WB_W-1:0]);
               if (used_ff != '0) begin
                  used_in = used_ff - CNT_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      sweep_ff     <= sweep_in;
      rd_idx_ff    <= rd_idx_in;
      chk_valid_ff <= chk_valid_in;
      chk_idx_ff   <= chk_idx_in;
      status_ff    <= status_in;
      paddr_ff     <= paddr_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign result.done         = (state_ff == ST_DONE);
   assign result.status       = status_ff;
   assign result.page_address = paddr_ff;
   assign used_count          = used_ff;
   assign page_total          = total_ff;

endmodule

### hdl/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to its top level.
module bpa_checker import bpa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // A stalled result word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // Only a successful allocate reports a page address.
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[OFS_FREE-1:OFS_PAGE_ADDR] == '0)
      else $error("page address set on a failed operation");

   // Free and used bytes always add up to the total.
   a_bytes_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> BYTES_W'(rsp_tdata[OFS_USED-1:OFS_FREE] + rsp_tdata[OFS_TOTAL-1:OFS_USED])
                     == rsp_tdata[OFS_TOTAL+BYTES_W-1:OFS_TOTAL])
      else $error("free plus used bytes differ from total bytes");

   // One operation at a time: no word is taken right after another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an operation is in progress");

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (.*);
